>>> src/cbr_pkg.sv
// ----------------------------------------------------------------------------
// cbr_pkg
// shared constants and types of the midpoint circle rasterizer
// ----------------------------------------------------------------------------
`default_nettype none

package cbr_pkg;

	// default coordinate width
	localparam int CBR_COORD_BITS = 11;

	// fixed field widths
	localparam int IN_COORD_W = 11;
	localparam int IN_RAD_W   = 10;
	localparam int PIX_W      = 13;
	localparam int DEC_W      = 16;

	// decision variable constants
	localparam logic [DEC_W-1:0] D_INIT  = 16'd3;
	localparam logic [DEC_W-1:0] D_DIAG  = 16'd10;
	localparam logic [DEC_W-1:0] D_AXIAL = 16'd6;

	// pixels emitted for one octant position
	localparam int PIX_PER_STEP = 8;
	localparam int PIX_IDX_W    = 3;

	// job queue depth between front and back
	localparam int QUEUE_DEPTH = 2;

	// item opcodes
	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	// job control carried from front to back
	typedef struct packed {
		logic pix;   // eight pixels, else one empty result
		logic done;  // octant finished
	} job_ctl_t;

endpackage

`default_nettype wire

>>> src/cbr_fifo.sv
// ----------------------------------------------------------------------------
// cbr_fifo
// small register queue with first-word fall-through head
// ----------------------------------------------------------------------------
`default_nettype none

module cbr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  space,
	input  wire logic             pop,
	output logic                  rvalid,
	output logic [WIDTH-1:0]      rdata
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign space  = (count_q != CNT_W'(DEPTH));
	assign rvalid = (count_q != '0);
	assign rdata  = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		n = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
		return n;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue popped while empty");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'(DEPTH) && !pop |=> count_q == CNT_W'(DEPTH) && !push)
		else $error("queue overfilled");

endmodule

`default_nettype wire

>>> src/cbr_front.sv
// ----------------------------------------------------------------------------
// cbr_front
// accepts items, runs the decision recurrence and queues pixel jobs
// ----------------------------------------------------------------------------
`default_nettype none

module cbr_front #(
	parameter int COORD_BITS = 11
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           item_valid,
	output logic                                item_ready,
	input  wire logic                           op,
	input  wire logic [cbr_pkg::IN_COORD_W-1:0] center_x,
	input  wire logic [cbr_pkg::IN_COORD_W-1:0] center_y,
	input  wire logic [cbr_pkg::IN_RAD_W-1:0]   radius,
	input  wire logic                           q_space,
	output logic                                push,
	output cbr_pkg::job_ctl_t                   job_ctl,
	output logic [COORD_BITS-1:0]               job_cx,
	output logic [COORD_BITS-1:0]               job_cy,
	output logic signed [COORD_BITS+1:0]        job_ox,
	output logic signed [COORD_BITS+1:0]        job_oy
);

	import cbr_pkg::*;

	localparam int OFF_W = COORD_BITS + 2;

	logic [COORD_BITS-1:0]   cx_q, cy_q, x_q, y_q;
	logic signed [DEC_W-1:0] d_q;
	logic                    active_q;

	logic [COORD_BITS-1:0]   r_w;
	logic [DEC_W-1:0]        x16, y16, d_start, d_step;
	logic                    diag;
	logic signed [OFF_W-1:0] nx, ny;
	logic                    fin;

	assign item_ready = q_space;
	assign push       = item_valid && q_space;

	always_comb begin
		r_w     = COORD_BITS'(radius);
		x16     = DEC_W'(x_q);
		y16     = DEC_W'(y_q);
		diag    = (d_q > 0);
		d_start = D_INIT - (DEC_W'(r_w) << 1);
		if (diag)
			d_step = d_q + ((x16 - y16) << 2) + D_DIAG;
		else
			d_step = d_q + (x16 << 2) + D_AXIAL;
		nx  = {2'b00, x_q} + OFF_W'(1);
		ny  = diag ? {2'b00, y_q} - OFF_W'(1) : {2'b00, y_q};
		fin = (ny < nx);
	end

	always_comb begin
		job_cx = cx_q;
		job_cy = cy_q;
		job_ox = nx;
		job_oy = ny;
		job_ctl.pix  = 1'b1;
		job_ctl.done = fin;
		case (op)
			OP_START: begin
				job_cx       = COORD_BITS'(center_x);
				job_cy       = COORD_BITS'(center_y);
				job_ox       = '0;
				job_oy       = {2'b00, r_w};
				job_ctl.done = 1'b0;
			end
			OP_STEP: begin
				if (!active_q) begin
					job_ctl.pix  = 1'b0;
					job_ctl.done = 1'b1;
				end
			end
			default: begin
				job_ctl.pix = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= '0;
			cy_q     <= '0;
			x_q      <= '0;
			y_q      <= '0;
			d_q      <= '0;
			active_q <= 1'b0;
		end else if (push) begin
			if (op == OP_START) begin
				cx_q     <= COORD_BITS'(center_x);
				cy_q     <= COORD_BITS'(center_y);
				x_q      <= '0;
				y_q      <= r_w;
				d_q      <= d_start;
				active_q <= 1'b1;
			end else if (active_q) begin
				x_q <= nx[COORD_BITS-1:0];
				y_q <= ny[COORD_BITS-1:0];
				d_q <= d_step;
				if (fin)
					active_q <= 1'b0;
			end
		end
	end

	a_idle_step_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		push && op == OP_STEP && !active_q |=> !active_q && $stable(x_q) && $stable(d_q))
		else $error("step without a circle changed state");

endmodule

`default_nettype wire

>>> src/cbr_back.sv
// ----------------------------------------------------------------------------
// cbr_back
// expands a queued job into its mirrored pixels, one per cycle while res_ready allows
// ----------------------------------------------------------------------------
`default_nettype none

module cbr_back #(
	parameter int COORD_BITS = 11
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          head_valid,
	output logic                               pop,
	input  wire cbr_pkg::job_ctl_t             head_ctl,
	input  wire logic [COORD_BITS-1:0]         head_cx,
	input  wire logic [COORD_BITS-1:0]         head_cy,
	input  wire logic signed [COORD_BITS+1:0]  head_ox,
	input  wire logic signed [COORD_BITS+1:0]  head_oy,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output logic signed [cbr_pkg::PIX_W-1:0]   pixel_x,
	output logic signed [cbr_pkg::PIX_W-1:0]   pixel_y,
	output logic                               pixel_valid,
	output logic                               last,
	output logic                               done_res
);

	import cbr_pkg::*;

	localparam int OFF_W = COORD_BITS + 2;
	localparam int SUM_W = (OFF_W > PIX_W) ? OFF_W : PIX_W;

	logic [PIX_IDX_W-1:0]    k_q;
	logic                    res_valid_q;
	logic [PIX_W-1:0]        pixel_x_q, pixel_y_q;
	logic                    pixel_valid_q, last_q, done_q;

	logic                    ld, fire, is_last;
	logic signed [OFF_W-1:0] a_col, a_row;
	logic [SUM_W-1:0]        cxw, cyw, acw, arw, col, row;

	assign ld      = !res_valid_q || res_ready;
	assign fire    = ld && head_valid;
	assign is_last = !head_ctl.pix || (k_q == PIX_IDX_W'(PIX_PER_STEP - 1));
	assign pop     = fire && is_last;

	// k[2] swaps axes, k[0] mirrors the column, k[1] mirrors the row
	always_comb begin
		a_col = k_q[2] ? head_oy : head_ox;
		a_row = k_q[2] ? head_ox : head_oy;
		cxw   = SUM_W'(head_cx);
		cyw   = SUM_W'(head_cy);
		acw   = SUM_W'(a_col);
		arw   = SUM_W'(a_row);
		col   = k_q[0] ? cxw - acw : cxw + acw;
		row   = k_q[1] ? cyw - arw : cyw + arw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			k_q         <= '0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
			k_q         <= is_last ? '0 : k_q + PIX_IDX_W'(1);
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (head_ctl.pix) begin
				pixel_x_q     <= col[PIX_W-1:0];
				pixel_y_q     <= row[PIX_W-1:0];
				pixel_valid_q <= 1'b1;
			end else begin
				pixel_x_q     <= '0;
				pixel_y_q     <= '0;
				pixel_valid_q <= 1'b0;
			end
			last_q <= is_last;
			done_q <= head_ctl.done;
		end
	end

	assign res_valid   = res_valid_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign pixel_valid = pixel_valid_q;
	assign last        = last_q;
	assign done_res    = done_q;

	a_empty_result_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !pixel_valid_q |-> last_q && done_q)
		else $error("empty result without last and done");

	a_mid_job_head_held: assert property (@(posedge clk) disable iff (!arst_n)
		k_q != '0 |-> head_valid && head_ctl.pix)
		else $error("job left the queue before its last pixel");

endmodule

`default_nettype wire

>>> src/circle_bresenham_rasterizer.sv
// ----------------------------------------------------------------------------
// circle_bresenham_rasterizer
// midpoint circle generator emitting eight-way mirrored pixels
// ----------------------------------------------------------------------------
//
//   channel  signals                        dir  payload
//   -------  -----------------------------  ---  ------------------------------
//   item     item_valid / item_ready        in   op, center_x, center_y, radius
//   result   res_valid / res_ready          out  pixel_x, pixel_y, pixel_valid,
//                                                last, done_res
//
// - a start or active step gives eight result beats, a step with no circle one
// - the result port moves one beat per cycle while res_ready holds; a pixel step fills eight beats
// - an item's first beat passes the job queue, then the output register
// - the front takes an item each cycle while the two-entry job queue has room
// - reset clears the circle state, the queue and the output valid flag
//
`default_nettype none

module circle_bresenham_rasterizer #(
	parameter int COORD_BITS = cbr_pkg::CBR_COORD_BITS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// item channel
	input  wire logic                           item_valid,
	output logic                                item_ready,
	input  wire logic                           op,
	input  wire logic [cbr_pkg::IN_COORD_W-1:0] center_x,
	input  wire logic [cbr_pkg::IN_COORD_W-1:0] center_y,
	input  wire logic [cbr_pkg::IN_RAD_W-1:0]   radius,
	// result channel
	output logic                                res_valid,
	input  wire logic                           res_ready,
	output logic signed [cbr_pkg::PIX_W-1:0]    pixel_x,
	output logic signed [cbr_pkg::PIX_W-1:0]    pixel_y,
	output logic                                pixel_valid,
	output logic                                last,
	output logic                                done_res
);

	import cbr_pkg::*;

	// offsets carry two extra bits: x may pass 2^COORD_BITS-1, y may reach -1
	localparam int OFF_W = COORD_BITS + 2;
	localparam int CTL_W = $bits(job_ctl_t);
	localparam int JOB_W = CTL_W + 2 * COORD_BITS + 2 * OFF_W;

	// front side job
	logic                    push, q_space;
	job_ctl_t                f_ctl;
	logic [COORD_BITS-1:0]   f_cx, f_cy;
	logic signed [OFF_W-1:0] f_ox, f_oy;

	// queue head as seen by the back
	logic                    head_valid, pop;
	logic [JOB_W-1:0]        wdata, rdata;
	job_ctl_t                h_ctl;
	logic [COORD_BITS-1:0]   h_cx, h_cy;
	logic signed [OFF_W-1:0] h_ox, h_oy;

	// front: classifies the item and advances the decision variable at accept
	cbr_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.op        (op),
		.center_x  (center_x),
		.center_y  (center_y),
		.radius    (radius),
		.q_space   (q_space),
		.push      (push),
		.job_ctl   (f_ctl),
		.job_cx    (f_cx),
		.job_cy    (f_cy),
		.job_ox    (f_ox),
		.job_oy    (f_oy)
	);

	assign wdata = {f_ctl, f_cx, f_cy, f_ox, f_oy};

	// job queue decouples the recurrence from the pixel port
	cbr_fifo #(
		.WIDTH(JOB_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (wdata),
		.space (q_space),
		.pop   (pop),
		.rvalid(head_valid),
		.rdata (rdata)
	);

	assign {h_ctl, h_cx, h_cy, h_ox, h_oy} = rdata;

	// back: walks the eight octant mirrors into the output register
	cbr_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.pop        (pop),
		.head_ctl   (h_ctl),
		.head_cx    (h_cx),
		.head_cy    (h_cy),
		.head_ox    (h_ox),
		.head_oy    (h_oy),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.pixel_valid(pixel_valid),
		.last       (last),
		.done_res   (done_res)
	);

endmodule

`default_nettype wire
